// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// In synthesis builds every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property that is switched off while reset is asserted.
`define LSCD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that is also evaluated across reset.
`define LSCD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LSCD_ASSERT(name, clk, rst_n, prop, msg)
`define LSCD_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ----- rtl/lscd_pkg.sv -----
package lscd_pkg;

  // Field widths.
  localparam int DIST_W     = 14;
  localparam int DELTA_W    = 24;
  localparam int HITS_W     = 16;
  localparam int ANGLE_W    = 9;
  localparam int APER_W     = 8;
  localparam int THR_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Divisor of the window mean is 2*aperture+1, which fits one bit more than the aperture.
  localparam int DIVR_W         = APER_W + 1;
  // Quotient bits resolved per divider cycle.
  localparam int DIV_RADIX_BITS = 4;

  localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};
  localparam logic [HITS_W-1:0]  HITS_MAX  = {HITS_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_APERTURE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATE = 2'd2;

  // Configuration reset values.
  localparam logic [APER_W-1:0] APERTURE_RST   = 8'd45;
  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 14'd100;
  localparam logic              ACCUMULATE_RST = 1'b0;

  // Request kinds.
  localparam logic KIND_POINT     = 1'b0;
  localparam logic KIND_SWEEP_END = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [ANGLE_W-1:0] angle_deg;
    logic [DIST_W-1:0]  distance_mm;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0]  point_delta;
    logic [HITS_W-1:0]  hit_count;
    logic [DELTA_W-1:0] mean_delta;
  } out_t;

  // One table entry: reference distance, working distance and change delta.
  typedef struct packed {
    logic [DIST_W-1:0]  ref_mm;
    logic [DIST_W-1:0]  work_mm;
    logic [DELTA_W-1:0] delta;
  } mem_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESCAN,
    ST_SWEEP,
    ST_UPDATE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/lidar_sweep_change_detector.sv -----
// Sweep change detector. One table entry per whole degree holds the reference
// distance, the working distance and the change delta in a single-port-read,
// single-port-write memory. A point request reads its entry, updates it in the
// next cycle and then divides the running window sum by 2*aperture+1 in a
// divider that resolves four quotient bits per cycle. The next request is taken
// once the result has been loaded into the output register, so a stalled result
// holds it off; an ignored angle skips the table update state.
// An end-of-sweep request copies the working column into the reference column
// and clears the deltas, one entry per cycle, and then runs the divide. After
// reset the memory is cleared before the first request is taken. Writing the
// aperture register starts, once the controller is idle, a rescan of the delta
// column that rebuilds the window sum; no request is taken meanwhile.
// Configuration writes are always accepted.
`include "assert_macros.svh"

module lidar_sweep_change_detector
  import lscd_pkg::*;
#(
  parameter int NUM_DEGREES = 360
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEG_W = $clog2(NUM_DEGREES);
  localparam int SUM_W = DELTA_W + DEG_W;
  localparam int CW    = ((DEG_W > APER_W) ? DEG_W : APER_W) + 1;
  localparam int AW    = ((DEG_W > ANGLE_W) ? DEG_W : ANGLE_W) + 1;
  localparam int LIM   = (NUM_DEGREES - 1) / 2;
  localparam int APMAX = (1 << APER_W) - 1;
  localparam int LIM_C = (LIM > APMAX) ? APMAX : LIM;
  localparam logic [DEG_W-1:0]  LAST_IDX = DEG_W'(NUM_DEGREES - 1);
  localparam logic [APER_W-1:0] AP_LIM   = APER_W'(LIM_C);

  // True when a degree lies in the window around zero.
  function automatic logic in_win(input logic [DEG_W-1:0] deg, input logic [APER_W-1:0] ap);
    logic [CW-1:0] d;
    logic [CW-1:0] a;
    logic [CW-1:0] hi;
    d  = CW'(deg);
    a  = CW'(ap);
    hi = CW'(NUM_DEGREES) - a;
    return (d <= a) || (d >= hi);
  endfunction

  state_t             state_r, state_nxt;
  logic [DEG_W-1:0]   ptr_r, ptr_nxt;
  logic [APER_W-1:0]  aperture_r;
  logic [THR_W-1:0]   thr_r;
  logic               acc_r;
  logic               rescan_pend_r, rescan_pend_nxt;
  in_t                item_r;
  logic [DEG_W-1:0]   idx_r;
  logic [HITS_W-1:0]  hits_r, hits_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [DIST_W-1:0]  diff_r, diff_nxt;
  logic               rescan_vld_r;
  logic               copy_vld_r;
  logic [DEG_W-1:0]   scan_idx_r;
  logic               out_valid_r;
  out_t               out_data_r;

  mem_word_t          mem [NUM_DEGREES];
  mem_word_t          mem_q_r;
  logic               rd_en;
  logic [DEG_W-1:0]   rd_addr;
  logic               wr_en;
  logic [DEG_W-1:0]   wr_addr;
  mem_word_t          wr_data;

  logic               div_start;
  logic               div_done;
  logic [DELTA_W-1:0] div_quo;
  logic               out_load;

  logic               cfg_acc;
  logic               in_acc;
  logic               ptr_last;
  logic [APER_W-1:0]  eff_ap;
  logic [AW-1:0]      in_ang;
  logic               angle_ok;
  logic [DEG_W-1:0]   in_idx;

  logic [DIST_W-1:0]  diff_abs;
  logic               upd_win;
  logic               upd_take;
  logic [DELTA_W:0]   acc_sum;
  logic [DELTA_W-1:0] new_delta;
  logic [DIST_W-1:0]  new_work;
  logic               hit_inc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && in_ready;
  assign ptr_last  = (ptr_r == LAST_IDX);

  // Apertures wider than half the circle are clipped so no degree counts twice.
  assign eff_ap = (aperture_r > AP_LIM) ? AP_LIM : aperture_r;

  assign in_ang   = AW'(in_data.angle_deg);
  assign angle_ok = (in_ang < AW'(NUM_DEGREES));
  assign in_idx   = DEG_W'(in_ang);

  // Configuration registers; writes to an unknown index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aperture_r <= APERTURE_RST;
      thr_r      <= THRESHOLD_RST;
      acc_r      <= ACCUMULATE_RST;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_APERTURE: begin
          aperture_r <= cfg_data[APER_W-1:0];
        end
        REG_THRESHOLD: begin
          thr_r <= cfg_data[THR_W-1:0];
        end
        REG_ACCUMULATE: begin
          acc_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // A new aperture changes the window, so the window sum must be rebuilt.
  always_comb begin
    rescan_pend_nxt = rescan_pend_r;
    if (state_r == ST_IDLE) begin
      rescan_pend_nxt = 1'b0;
    end
    if (cfg_acc && (cfg_index == REG_APERTURE)) begin
      rescan_pend_nxt = 1'b1;
    end
  end

  // Read-modify-write of one point entry.
  always_comb begin
    diff_abs  = (mem_q_r.ref_mm > item_r.distance_mm) ?
                mem_q_r.ref_mm - item_r.distance_mm :
                item_r.distance_mm - mem_q_r.ref_mm;
    upd_win   = in_win(idx_r, eff_ap);
    upd_take  = (DELTA_W'(diff_abs) > mem_q_r.delta) && upd_win;
    acc_sum   = {1'b0, mem_q_r.delta} + (DELTA_W + 1)'(diff_abs);
    if (acc_r) begin
      new_delta = acc_sum[DELTA_W] ? DELTA_MAX : acc_sum[DELTA_W-1:0];
    end else begin
      new_delta = upd_take ? DELTA_W'(diff_abs) : mem_q_r.delta;
    end
    new_work  = upd_take ? item_r.distance_mm : mem_q_r.work_mm;
    hit_inc   = upd_take && (diff_abs > thr_r) && (hits_r != HITS_MAX);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (ptr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (rescan_pend_r) begin
          state_nxt = ST_RESCAN;
        end else if (in_valid) begin
          if (in_data.kind == KIND_SWEEP_END) begin
            state_nxt = ST_SWEEP;
          end else if (angle_ok) begin
            state_nxt = ST_UPDATE;
          end else begin
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_RESCAN: begin
        if (ptr_last) state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        if (ptr_last) state_nxt = ST_DIV_GO;
      end
      ST_UPDATE: begin
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State outputs: memory ports, divider start, result load.
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = ptr_r;
    wr_en     = 1'b0;
    wr_addr   = ptr_r;
    wr_data   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    // The copy write follows the sweep read in the next cycle.
    if (copy_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = scan_idx_r;
      wr_data = {mem_q_r.work_mm, mem_q_r.work_mm, DELTA_W'(0)};
    end
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = '0;
      end
      ST_IDLE: begin
        in_ready = !rescan_pend_r;
        rd_en    = in_valid && !rescan_pend_r &&
                   (in_data.kind == KIND_POINT) && angle_ok;
        rd_addr  = in_idx;
      end
      ST_RESCAN, ST_SWEEP: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r;
      end
      ST_UPDATE: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = {mem_q_r.ref_mm, new_work, new_delta};
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  // Scan pointer for clearing, sweep copy and rescan; it wraps to zero at the end.
  always_comb begin
    ptr_nxt = ptr_r;
    if ((state_r == ST_CLEAR) || (state_r == ST_RESCAN) || (state_r == ST_SWEEP)) begin
      ptr_nxt = ptr_last ? '0 : ptr_r + DEG_W'(1);
    end
  end

  // Hit counter.
  always_comb begin
    hits_nxt = hits_r;
    priority if (in_acc && (in_data.kind == KIND_SWEEP_END)) begin
      hits_nxt = '0;
    end else if ((state_r == ST_UPDATE) && hit_inc) begin
      hits_nxt = hits_r + HITS_W'(1);
    end else begin
      hits_nxt = hits_r;
    end
  end

  // Running sum of the deltas inside the window. Deltas only grow between
  // sweeps, so an update adds the increase of its entry.
  always_comb begin
    sum_nxt = sum_r;
    priority if (in_acc && (in_data.kind == KIND_SWEEP_END)) begin
      sum_nxt = '0;
    end else if ((state_r == ST_IDLE) && rescan_pend_r) begin
      sum_nxt = '0;
    end else if (rescan_vld_r) begin
      if (in_win(scan_idx_r, eff_ap)) begin
        sum_nxt = sum_r + SUM_W'(mem_q_r.delta);
      end
    end else if ((state_r == ST_UPDATE) && upd_win) begin
      sum_nxt = sum_r + SUM_W'(new_delta - mem_q_r.delta);
    end else begin
      sum_nxt = sum_r;
    end
  end

  // Point delta reported with the result.
  always_comb begin
    diff_nxt = diff_r;
    priority if (in_acc) begin
      diff_nxt = '0;
    end else if (state_r == ST_UPDATE) begin
      diff_nxt = diff_abs;
    end else begin
      diff_nxt = diff_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      ptr_r         <= '0;
      rescan_pend_r <= 1'b0;
      hits_r        <= '0;
      sum_r         <= '0;
      rescan_vld_r  <= 1'b0;
      copy_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ptr_r         <= ptr_nxt;
      rescan_pend_r <= rescan_pend_nxt;
      hits_r        <= hits_nxt;
      sum_r         <= sum_nxt;
      rescan_vld_r  <= (state_r == ST_RESCAN);
      copy_vld_r    <= (state_r == ST_SWEEP);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx_r <= ptr_r;
    diff_r     <= diff_nxt;
    if (in_acc) begin
      item_r <= in_data;
      idx_r  <= in_idx;
    end
    if (out_load) begin
      out_data_r.point_delta <= diff_r;
      out_data_r.hit_count   <= hits_r;
      out_data_r.mean_delta  <= div_quo;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Window mean divider.
  lscd_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  ({eff_ap, 1'b1}),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The copy write and the read of the next entry never touch the same address.
  `LSCD_ASSERT(a_no_rw_clash, clk, rst_n, (wr_en && rd_en) |-> (wr_addr != rd_addr), "read and write hit the same entry")
  // No request is taken while the sweep copy is still writing back.
  `LSCD_ASSERT(a_accept_after_copy, clk, rst_n, (in_valid && in_ready) |-> !copy_vld_r, "request accepted during sweep copy")
  // The divider finishes only while the controller waits for it.
  `LSCD_ASSERT(a_div_done_expected, clk, rst_n, div_done |-> (state_r == ST_DIV_WAIT), "unexpected divider completion")
  // A point update never lowers the hit count.
  `LSCD_ASSERT(a_hits_grow, clk, rst_n, (state_r == ST_UPDATE) |=> (hits_r >= $past(hits_r)), "hit count decreased on update")
  // Reset always restarts the clearing pass with no result pending.
  `LSCD_ASSERT_ALWAYS(a_reset_clear, clk, (!rst_n) |=> ((state_r == ST_CLEAR) && !out_valid_r), "reset did not restart clearing")

endmodule

// ----- rtl/lscd_div.sv -----
module lscd_div
  import lscd_pkg::*;
#(
  parameter int SUM_W = 33
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [DIVR_W-1:0]  divisor,
  output logic               done,
  output logic [DELTA_W-1:0] quotient
);

  localparam int DIV_STEPS = (SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int PAD_W     = DIV_STEPS * DIV_RADIX_BITS;
  localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVR_W:0]   rem_r;
  logic [DIVR_W:0]   rem_nxt;
  logic [PAD_W-1:0]  quo_r;
  logic [PAD_W-1:0]  quo_nxt;
  logic [DIVR_W-1:0] dvs_r;

  // Restoring division, several quotient bits per cycle. The dividend shifts out
  // of the top of quo_r while quotient bits shift in at the bottom.
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int j = 0; j < DIV_RADIX_BITS; j++) begin
      rem_nxt = {rem_nxt[DIVR_W-1:0], quo_nxt[PAD_W-1]};
      quo_nxt = {quo_nxt[PAD_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dvs_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  // Control: start loads the operands, then DIV_STEPS iterations follow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= PAD_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // The mean never exceeds the largest delta, so the low bits hold it whole.
  assign done     = done_r;
  assign quotient = quo_r[DELTA_W-1:0];

endmodule
